// ===== src/nts_pkg.sv =====
// ----------------------------------------------------------------------------
// nts_pkg
// Shared types and constants of the nearest timestamp search block.
// ----------------------------------------------------------------------------
`default_nettype none

package nts_pkg;

	// Default number of table entries.
	localparam int TABLE_DEPTH_DEF = 1024;

	// Field widths of the items and of the entry count register.
	localparam int ADDRESS_W = 10;
	localparam int TIME_W    = 64;
	localparam int INDEX_W   = 10;
	localparam int COUNT_W   = 11;

	// Action codes of an input item.
	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_SEARCH = 1'b1;

	// One input item.
	typedef struct packed {
		logic                 action;
		logic [ADDRESS_W-1:0] entry_address;
		logic [TIME_W-1:0]    time_value;
	} query_t;

	// One result item.
	typedef struct packed {
		logic [INDEX_W-1:0] nearest_index;
		logic [TIME_W-1:0]  nearest_time;
	} answer_t;

endpackage

`default_nettype wire

// ===== src/nts_ram.sv =====
// ----------------------------------------------------------------------------
// nts_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module nts_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== src/nts_ctrl.sv =====
// ----------------------------------------------------------------------------
// nts_ctrl
// Search sequencer: stores write items in the table RAM and walks the binary
// search over it, one probe per cycle, then hands the result on.
// ----------------------------------------------------------------------------
`default_nettype none

module nts_ctrl import nts_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           query_valid,
	output logic                                query_stall,
	input  wire query_t                         query,
	input  wire logic                           cfg_wr_en,
	input  wire logic [COUNT_W-1:0]             cfg_wr_data,
	output logic                                res_valid,
	output answer_t                             res,
	input  wire logic                           res_stall,
	output logic                                mem_we,
	output logic [$clog2(TABLE_DEPTH)-1:0]      mem_waddr,
	output logic [TIME_W-1:0]                   mem_wdata,
	output logic [$clog2(TABLE_DEPTH)-1:0]      mem_raddr,
	input  wire logic [TIME_W-1:0]              mem_rdata
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int EW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_PROBE   = 3'd1;
	localparam logic [2:0] S_FINAL   = 3'd2;
	localparam logic [2:0] S_READ_LO = 3'd3;
	localparam logic [2:0] S_READ_HI = 3'd4;
	localparam logic [2:0] S_DONE    = 3'd5;

	function automatic logic [TIME_W-1:0] abs_diff(input logic [TIME_W-1:0] a,
		input logic [TIME_W-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	function automatic logic [INDEX_W-1:0] to_index(input logic [AW-1:0] v);
		logic [EW-1:0] t;
		t = EW'(v);
		return t[INDEX_W-1:0];
	endfunction

	logic [2:0]          state_q;
	logic [AW-1:0]       low_q, high_q, mid_q;
	logic [COUNT_W-1:0]  count_q;
	logic [TIME_W-1:0]   target_q, lo_dist_q, lo_time_q;
	answer_t             res_q;

	logic                accept;
	logic [EW-1:0]       cnt_e, n_e, n_m1, addr_e;
	logic                probe_lt, probe_eq;
	logic [AW-1:0]       cand_lo, cand_hi, cand_mid, cand_diff;
	logic [AW:0]         cand_sum;
	logic [2:0]          plan_state;
	logic [AW-1:0]       plan_addr;
	logic [TIME_W-1:0]   hi_dist;

	assign accept      = query_valid && !query_stall;
	assign query_stall = (state_q != S_IDLE);
	assign res_valid   = (state_q == S_DONE);
	assign res         = res_q;

	// Effective entry count: zero searches as one, large counts clamp to depth.
	always_comb begin
		cnt_e = EW'(count_q);
		n_e   = cnt_e;
		if (count_q == '0) begin
			n_e = EW'(1);
		end else if (cnt_e > EW'(TABLE_DEPTH)) begin
			n_e = EW'(TABLE_DEPTH);
		end
		n_m1 = n_e - EW'(1);
	end

	// Table writes; addresses beyond the depth are dropped.
	assign addr_e    = EW'(query.entry_address);
	assign mem_we    = accept && (query.action == ACT_WRITE) && (addr_e < EW'(TABLE_DEPTH));
	assign mem_waddr = addr_e[AW-1:0];
	assign mem_wdata = query.time_value;

	// Probe outcome and the next pair of bounds.
	assign probe_eq = (mem_rdata == target_q);
	assign probe_lt = (mem_rdata < target_q);

	always_comb begin
		if (state_q == S_PROBE) begin
			cand_lo = probe_lt ? mid_q : low_q;
			cand_hi = probe_lt ? high_q : mid_q;
		end else begin
			cand_lo = '0;
			cand_hi = n_m1[AW-1:0];
		end
		cand_sum  = {1'b0, cand_lo} + {1'b0, cand_hi};
		cand_mid  = cand_sum[AW:1];
		cand_diff = cand_hi - cand_lo;
		if (cand_lo == cand_hi) begin
			plan_state = S_FINAL;
		end else if (cand_diff == AW'(1)) begin
			plan_state = S_READ_LO;
		end else begin
			plan_state = S_PROBE;
		end
		plan_addr = (plan_state == S_PROBE) ? cand_mid : cand_lo;
	end

	// Read address for the next cycle.
	always_comb begin
		case (state_q)
			S_IDLE, S_PROBE: mem_raddr = plan_addr;
			S_READ_LO:       mem_raddr = high_q;
			default:         mem_raddr = low_q;
		endcase
	end

	assign hi_dist = abs_diff(target_q, mem_rdata);

	// Control state: sequencer, bounds and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			low_q   <= '0;
			high_q  <= '0;
			count_q <= COUNT_W'(1);
		end else begin
			if (cfg_wr_en) begin
				count_q <= cfg_wr_data;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && (query.action == ACT_SEARCH)) begin
						low_q   <= cand_lo;
						high_q  <= cand_hi;
						state_q <= plan_state;
					end
				end
				S_PROBE: begin
					if (probe_eq) begin
						state_q <= S_DONE;
					end else begin
						low_q   <= cand_lo;
						high_q  <= cand_hi;
						state_q <= plan_state;
					end
				end
				S_FINAL:   state_q <= S_DONE;
				S_READ_LO: state_q <= S_READ_HI;
				S_READ_HI: state_q <= S_DONE;
				S_DONE: begin
					if (!res_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers: search time, midpoint, lower neighbor, result.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				target_q <= query.time_value;
				mid_q    <= cand_mid;
			end
			S_PROBE: begin
				mid_q             <= cand_mid;
				res_q.nearest_index <= to_index(mid_q);
				res_q.nearest_time  <= mem_rdata;
			end
			S_FINAL: begin
				res_q.nearest_index <= to_index(low_q);
				res_q.nearest_time  <= mem_rdata;
			end
			S_READ_LO: begin
				lo_dist_q <= abs_diff(target_q, mem_rdata);
				lo_time_q <= mem_rdata;
			end
			S_READ_HI: begin
				// The closer neighbor wins; a tie goes to the higher index.
				if (lo_dist_q < hi_dist) begin
					res_q.nearest_index <= to_index(low_q);
					res_q.nearest_time  <= lo_time_q;
				end else begin
					res_q.nearest_index <= to_index(high_q);
					res_q.nearest_time  <= mem_rdata;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== src/nts_out_reg.sv =====
// ----------------------------------------------------------------------------
// nts_out_reg
// Output holding register between the search sequencer and the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module nts_out_reg import nts_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    res_valid,
	input  wire answer_t res,
	output logic         res_stall,
	output logic         answer_valid,
	input  wire logic    answer_stall,
	output answer_t      answer
);

	logic    valid_q;
	answer_t data_q;

	// The register takes a new item when empty or when its item leaves now.
	assign res_stall    = valid_q && answer_stall;
	assign answer_valid = valid_q;
	assign answer       = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!res_stall) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && !res_stall) begin
			data_q <= res;
		end
	end

endmodule

`default_nettype wire

// ===== src/nearest_timestamp_search.sv =====
// ----------------------------------------------------------------------------
// nearest_timestamp_search
// Table of ascending timestamps with a binary search for the nearest entry.
// ----------------------------------------------------------------------------
// Usage:
// Input items arrive on query_valid / query_stall. A write item stores
// time_value at entry_address and gives no result.
// A search item gives one result item on answer_valid / answer_stall with the
// index and stored time of the entry nearest the search time among the first
// entry_count entries. Program entry_count with cfg_wr_en / cfg_wr_data while
// the block is idle.
// A search walks the table RAM, one probe per cycle (at most about
// log2(entry_count) probes), then reads and compares the two last
// neighbors and hands the result over. The single read port of the table
// RAM paces the probes.
// The result sits in an output register, so write items are taken while it
// waits; a further search completes and then holds until the receiver drops
// answer_stall. Reset clears the sequencer and the output register and sets
// entry_count to one; the table contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_timestamp_search import nts_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               query_valid,
	output logic                    query_stall,
	input  wire query_t             query,
	output logic                    answer_valid,
	input  wire logic               answer_stall,
	output answer_t                 answer,
	input  wire logic               cfg_wr_en,
	input  wire logic [COUNT_W-1:0] cfg_wr_data
);

	localparam int AW = $clog2(TABLE_DEPTH);

	logic              mem_we;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [TIME_W-1:0] mem_wdata, mem_rdata;
	logic              res_valid, res_stall;
	answer_t           res;

	// Timestamp table.
	nts_ram #(
		.WIDTH (TIME_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Search sequencer.
	nts_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.query_valid (query_valid),
		.query_stall (query_stall),
		.query       (query),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.res_valid   (res_valid),
		.res         (res),
		.res_stall   (res_stall),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata)
	);

	// Output register.
	nts_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_valid    (res_valid),
		.res          (res),
		.res_stall    (res_stall),
		.answer_valid (answer_valid),
		.answer_stall (answer_stall),
		.answer       (answer)
	);

endmodule

`default_nettype wire

// ===== src/nts_checker.sv =====
// ----------------------------------------------------------------------------
// nts_checker
// Port-level checks of the nearest timestamp search block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module nts_checker import nts_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    query_valid,
	input wire logic    query_stall,
	input wire query_t  query,
	input wire logic    answer_valid,
	input wire logic    answer_stall,
	input wire answer_t answer
);

	// A stalled result item holds.
	a_answer_hold: assert property (@(posedge clk) disable iff (!arst_n)
		answer_valid && answer_stall |=> answer_valid && $stable(answer))
		else $error("stalled result item changed");

	// A search item keeps the input side busy for at least the next cycle.
	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		query_valid && !query_stall && (query.action == ACT_SEARCH) |=> query_stall)
		else $error("input taken right after a search item");

	// A write item leaves the input side free in the next cycle.
	a_write_quick: assert property (@(posedge clk) disable iff (!arst_n)
		query_valid && !query_stall && (query.action == ACT_WRITE) |=> !query_stall)
		else $error("input busy after a write item");

	// A new result item only follows a search in progress.
	a_answer_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(answer_valid) |-> $past(query_stall))
		else $error("result item without a search");

endmodule

bind nearest_timestamp_search nts_checker u_nts_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nearest timestamp search block.
// The whole table is loaded with ascending stamps, then directed searches hit
// the table ends, exact probes, ties and the entry count limits. Random phases
// reload short tables, mostly sorted, and search near stored stamps, with
// scattered writes as noise. A scoreboard predicts every answer in order and
// compares it field by field while both sides idle and stall at random.
// ----------------------------------------------------------------------------
import nts_pkg::*;

// Predicts answers from its own copy of the table and the entry count.
class nearest_scoreboard;
	bit [TIME_W-1:0]  stamps [TABLE_DEPTH_DEF];
	bit [COUNT_W-1:0] entry_count;
	answer_t          expected_answers [$];
	int               errors;
	int               searches;
	int               writes;
	int               settings;

	function new();
		entry_count = 1;
		errors = 0;
		searches = 0;
		writes = 0;
		settings = 0;
	endfunction

	function void set_count(bit [COUNT_W-1:0] value);
		entry_count = value;
		settings++;
	endfunction

	function int pending();
		return expected_answers.size();
	endfunction

	function bit [TIME_W-1:0] distance(bit [TIME_W-1:0] a, bit [TIME_W-1:0] b);
		return (a >= b) ? a - b : b - a;
	endfunction

	// Walk the search bounds down to one index; ties between neighbors go high.
	function answer_t nearest_of(bit [TIME_W-1:0] target);
		int unsigned span;
		int unsigned low;
		int unsigned high;
		int unsigned mid;
		bit          found;
		answer_t     result;
		span = entry_count;
		if (span == 0) span = 1;
		if (span > TABLE_DEPTH_DEF) span = TABLE_DEPTH_DEF;
		low = 0;
		high = span - 1;
		found = 1'b0;
		while (!found) begin
			if (low == high) begin
				found = 1'b1;
			end else if (high - low == 1) begin
				if (distance(target, stamps[low]) >= distance(target, stamps[high]))
					low = high;
				found = 1'b1;
			end else begin
				mid = (low + high) / 2;
				if (stamps[mid] == target) begin
					low = mid;
					found = 1'b1;
				end else if (stamps[mid] < target) begin
					low = mid;
				end else begin
					high = mid;
				end
			end
		end
		result.nearest_index = INDEX_W'(low);
		result.nearest_time = stamps[low];
		return result;
	endfunction

	// An accepted write updates the table; a search queues its answer.
	function void note_query(query_t q);
		if (q.action == ACT_WRITE) begin
			stamps[q.entry_address] = q.time_value;
			writes++;
		end else begin
			expected_answers = {expected_answers, nearest_of(q.time_value)};
			searches++;
		end
	endfunction

	// Only the first hundred mismatches are printed; all of them are counted.
	task report(string what);
		errors++;
		if (errors <= 100) $display("ERROR at %0t: %s", $time, what);
	endtask

	task check_answer(answer_t got);
		answer_t want;
		if (expected_answers.size() == 0) begin
			report("answer arrived with no search outstanding");
			return;
		end
		want = expected_answers.pop_front();
		if (got.nearest_index !== want.nearest_index)
			report($sformatf("nearest_index %0d, predicted %0d",
				got.nearest_index, want.nearest_index));
		if (got.nearest_time !== want.nearest_time)
			report($sformatf("nearest_time %h, predicted %h",
				got.nearest_time, want.nearest_time));
	endtask
endclass

module tb_top;
	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 11;
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_ITEMS  = 600;
	localparam int LIMIT_CYCLES  = 800000;
	localparam bit [TIME_W-1:0] TIME_MAX = '1;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               query_valid = 1'b0;
	logic               query_stall;
	query_t             query = '0;
	logic               answer_valid;
	logic               answer_stall = 1'b0;
	answer_t            answer;
	logic               cfg_wr_en = 1'b0;
	logic [COUNT_W-1:0] cfg_wr_data = '0;

	int                 idle_pct = 0;
	int                 stall_pct = 0;
	nearest_scoreboard  sb;

	nearest_timestamp_search dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.query_valid  (query_valid),
		.query_stall  (query_stall),
		.query        (query),
		.answer_valid (answer_valid),
		.answer_stall (answer_stall),
		.answer       (answer),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	// Clock with a period of twelve units.
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// The receiver stalls at random according to the current phase.
	always @(posedge clk) begin
		answer_stall <= ($urandom_range(99) < stall_pct);
	end

	// Every accepted answer is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && answer_valid && !answer_stall) sb.check_answer(answer);
	end

	// Hard limit on the run in case the block hangs.
	initial begin
		#(LIMIT_CYCLES * 2 * CLK_HALF);
		$display("nearest_timestamp_search: mismatch");
		$finish;
	end

	task automatic set_mode(input int mode);
		case (mode)
			0: begin
				idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				idle_pct = 77;
				stall_pct = 0;
			end
			2: begin
				idle_pct = 0;
				stall_pct = 77;
			end
			default: begin
				idle_pct = 29;
				stall_pct = 29;
			end
		endcase
	endtask

	// Offer one item, with random gaps ahead of it, and hold it until taken.
	task automatic send_item(input query_t q);
		while ($urandom_range(99) < idle_pct) begin
			query_valid <= 1'b0;
			@(posedge clk);
		end
		query_valid <= 1'b1;
		query <= q;
		do @(posedge clk); while (query_stall);
		sb.note_query(q);
	endtask

	task automatic write_entry(input int unsigned addr, input bit [TIME_W-1:0] value);
		query_t q;
		q.action = ACT_WRITE;
		q.entry_address = ADDRESS_W'(addr);
		q.time_value = value;
		send_item(q);
	endtask

	// The address field is ignored on a search, so it carries random bits.
	task automatic search_for(input bit [TIME_W-1:0] target);
		query_t q;
		q.action = ACT_SEARCH;
		q.entry_address = ADDRESS_W'($urandom);
		q.time_value = target;
		send_item(q);
	endtask

	// Stop sending and wait until every predicted answer has come back.
	task automatic drain_answers();
		query_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// The count is written only once the block has gone quiet.
	task automatic program_count(input int unsigned value);
		drain_answers();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= COUNT_W'(value);
		@(posedge clk);
		sb.set_count(COUNT_W'(value));
		cfg_wr_en <= 1'b0;
	endtask

	function automatic int unsigned span_of(input int unsigned count);
		if (count == 0) return 1;
		if (count > TABLE_DEPTH_DEF) return TABLE_DEPTH_DEF;
		return count;
	endfunction

	// Fill the first entries with ascending stamps; even steps make exact ties.
	task automatic load_sorted(input int unsigned n);
		bit [TIME_W-1:0] stamp;
		int unsigned     shift;
		int unsigned     i;
		case ($urandom_range(2))
			0: stamp = '0;
			1: stamp = $urandom_range(1000);
			default: stamp = {$urandom >> 2, $urandom};
		endcase
		shift = $urandom_range(1, 40);
		for (i = 0; i < n; i++) begin
			write_entry(i, stamp);
			stamp += ({$urandom, $urandom} & ((64'd1 << shift) - 1)) & ~64'd1;
		end
	endtask

	task automatic load_scrambled(input int unsigned n);
		int unsigned i;
		for (i = 0; i < n; i++) write_entry(i, {$urandom, $urandom});
	endtask

	// Search times mostly near stored stamps, with the extremes mixed in.
	function automatic bit [TIME_W-1:0] pick_target(input int unsigned n);
		int unsigned     i;
		bit [TIME_W-1:0] lo;
		bit [TIME_W-1:0] hi;
		i = $urandom_range(n - 1);
		lo = sb.stamps[i];
		hi = sb.stamps[(i + 1 < n) ? i + 1 : i];
		case ($urandom_range(7))
			0: return lo;
			1: return lo + $urandom_range(1, 3);
			2: return lo - $urandom_range(1, 3);
			3, 4: return lo + ((hi - lo) >> 1);
			5: return $urandom_range(1) ? TIME_MAX : 64'd0;
			6: return {$urandom, $urandom};
			default: return hi + 1;
		endcase
	endfunction

	// Stimulus and the final verdict.
	initial begin
		bit [TIME_W-1:0] stamp;
		int unsigned     i;
		int unsigned     k;
		int unsigned     count;
		int unsigned     span;
		int unsigned     burst;
		int unsigned     random_items;
		int unsigned     phase;
		int unsigned     pick;
		sb = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Whole table ascending from zero up to the largest stamp.
		set_mode(0);
		program_count(TABLE_DEPTH_DEF);
		stamp = '0;
		for (i = 0; i < TABLE_DEPTH_DEF; i++) begin
			write_entry(i, (i == TABLE_DEPTH_DEF - 1) ? TIME_MAX : stamp);
			stamp += ({$urandom, $urandom} >> 12) & ~64'd1;
		end

		// Table ends, an exact hit on the first probe, a near miss and a tie.
		search_for('0);
		search_for(TIME_MAX);
		search_for(sb.stamps[511]);
		search_for(sb.stamps[300] + 1);
		search_for(sb.stamps[700] + ((sb.stamps[701] - sb.stamps[700]) >> 1));
		search_for(TIME_MAX - 1);

		// A count of zero behaves as one; two entries go straight to the compare.
		program_count(0);
		search_for(sb.stamps[9]);
		program_count(1);
		search_for(TIME_MAX);
		program_count(2);
		search_for(sb.stamps[1] >> 1);

		// Short table away from zero, searched from below and above its range.
		for (i = 0; i < 5; i++) write_entry(i, 100 * (i + 1));
		program_count(5);
		search_for('0);
		search_for(TIME_MAX);
		search_for(250);
		search_for(300);

		// Counts above the table depth are clamped.
		program_count(2047);
		search_for({$urandom, $urandom});
		program_count(1025);
		search_for(sb.stamps[TABLE_DEPTH_DEF - 1]);

		// Random phases: mostly short sorted tables, a few large counts.
		random_items = 0;
		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			set_mode(phase % 4);
			pick = $urandom_range(9);
			if (pick == 0) count = 0;
			else if (pick == 1) count = $urandom_range(TABLE_DEPTH_DEF + 1, 2047);
			else if (pick == 2) count = $urandom_range(65, TABLE_DEPTH_DEF);
			else count = $urandom_range(1, 64);
			program_count(count);
			span = span_of(count);
			if (span <= 64) begin
				if ($urandom_range(4) == 0) load_scrambled(span);
				else load_sorted(span);
				random_items += span;
			end
			burst = $urandom_range(15, 30);
			for (k = 0; k < burst; k++) begin
				// Now and then hold back until every answer is home.
				if (phase % 3 == 1 && k == burst / 2) drain_answers();
				if ($urandom_range(9) == 0)
					write_entry($urandom_range(1) ? $urandom_range(span - 1)
						: $urandom_range(TABLE_DEPTH_DEF - 1), {$urandom, $urandom});
				else
					search_for(pick_target(span));
				random_items++;
			end
			phase++;
		end

		drain_answers();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Ran %0d searches and %0d table writes over %0d entry count settings,",
			sb.searches, sb.writes, sb.settings);
		$display("with no gaps, one-sided gaps or stalls at 77%%, and both sides at 29%%.");
		if (sb.errors == 0) begin
			$display("nearest_timestamp_search: match");
		end else begin
			$display("nearest_timestamp_search: mismatch");
		end
		$finish;
	end
endmodule
